### src/lowest_common_ancestor_lifting_defines.svh
// Assertion macros shared by the checker of the ancestor lifting block.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef LOWEST_COMMON_ANCESTOR_LIFTING_DEFINES_SVH
`define LOWEST_COMMON_ANCESTOR_LIFTING_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LCAL_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LCAL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/lcal_pkg.sv
// Shared types and constants for the ancestor lifting block.
// No dependencies; every other module of the block except lcal_ram imports this package.
package lcal_pkg;

  localparam int NODE_W          = 10;
  localparam int DEPTH_W         = 11;
  localparam int CMD_W           = 2;
  localparam int MAX_NODES_DEF   = 1024;
  localparam int LIFT_LEVELS_DEF = 11;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_BUILD = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [NODE_W-1:0]  node_a;
    logic [NODE_W-1:0]  node_b;
    logic [DEPTH_W-1:0] node_depth;
  } in_item_t;

  typedef struct packed {
    logic [NODE_W-1:0] ancestor;
    cmd_t              done_kind;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_NONE   = 4'd0,
    OP_ACCEPT = 4'd1,
    OP_LOAD   = 4'd2,
    OP_BISSUE = 4'd3,
    OP_BNEXT  = 4'd4,
    OP_QDEP   = 4'd5,
    OP_QCMP   = 4'd6,
    OP_QLIFT  = 4'd7,
    OP_QLEND  = 4'd8,
    OP_QTOG   = 4'd9,
    OP_QTEND  = 4'd10,
    OP_QFIN   = 4'd11,
    OP_OUT    = 4'd12
  } dp_op_t;

  typedef struct packed {
    logic last_zero;
    logic j_at_last;
    logic pipe_empty;
    logic lvl_top;
    logic lvl_zero;
    logic x_eq_y;
  } dp_status_t;

endpackage

### src/lcal_ram.sv
// Generic RAM with one write port and two registered read ports.
// No dependencies.
module lcal_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  output logic [WIDTH-1:0]         rdata0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata0_r;
  logic [WIDTH-1:0] rdata1_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0_r <= mem[raddr0];
    rdata1_r <= mem[raddr1];
  end

  assign rdata0 = rdata0_r;
  assign rdata1 = rdata1_r;

endmodule

### src/lcal_ctrl.sv
// Controller state machine of the ancestor lifting block.
// Depends on lcal_pkg; drives the datapath operation and both handshakes.
module lcal_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  lcal_pkg::cmd_t      in_cmd,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output lcal_pkg::dp_op_t    op,
  input  lcal_pkg::dp_status_t status
);
  import lcal_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE   = 12'h001,
    S_LOAD   = 12'h002,
    S_BRUN   = 12'h004,
    S_BDRAIN = 12'h008,
    S_QDEP   = 12'h010,
    S_QCMP   = 12'h020,
    S_QLIFT  = 12'h040,
    S_QLEND  = 12'h080,
    S_QTOG   = 12'h100,
    S_QTEND  = 12'h200,
    S_QFIN   = 12'h400,
    S_DONE   = 12'h800
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    op        = OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op = OP_ACCEPT;
          unique case (in_cmd)
            CMD_LOAD:  state_nxt = S_LOAD;
            CMD_BUILD: state_nxt = status.last_zero ? S_DONE : S_BRUN;
            CMD_QUERY: state_nxt = S_QDEP;
            CMD_NONE:  state_nxt = S_DONE;
            default:   state_nxt = S_DONE;
          endcase
        end
      end
      S_LOAD: begin
        op        = OP_LOAD;
        state_nxt = S_DONE;
      end
      S_BRUN: begin
        op = OP_BISSUE;
        if (status.j_at_last) begin
          state_nxt = S_BDRAIN;
        end
      end
      S_BDRAIN: begin
        if (status.pipe_empty) begin
          if (status.lvl_top) begin
            state_nxt = S_DONE;
          end else begin
            op        = OP_BNEXT;
            state_nxt = S_BRUN;
          end
        end
      end
      S_QDEP: begin
        op        = OP_QDEP;
        state_nxt = S_QCMP;
      end
      S_QCMP: begin
        op        = OP_QCMP;
        state_nxt = S_QLIFT;
      end
      S_QLIFT: begin
        op = OP_QLIFT;
        if (status.lvl_zero) begin
          state_nxt = S_QLEND;
        end
      end
      S_QLEND: begin
        op        = OP_QLEND;
        state_nxt = status.x_eq_y ? S_DONE : S_QTOG;
      end
      S_QTOG: begin
        op = OP_QTOG;
        if (status.lvl_zero) begin
          state_nxt = S_QTEND;
        end
      end
      S_QTEND: begin
        op        = OP_QTEND;
        state_nxt = S_QFIN;
      end
      S_QFIN: begin
        op        = OP_QFIN;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          op        = OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = (op == OP_OUT) || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

### src/lcal_dp.sv
// Datapath of the ancestor lifting block: node store, ancestor table, lifting registers.
// Depends on lcal_pkg and lcal_ram; driven by lcal_ctrl through an operation code.
module lcal_dp #(
  parameter int MAX_NODES   = lcal_pkg::MAX_NODES_DEF,
  parameter int LIFT_LEVELS = lcal_pkg::LIFT_LEVELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lcal_pkg::dp_op_t              op,
  output lcal_pkg::dp_status_t          status,
  input  lcal_pkg::in_item_t            in_data,
  input  logic                          cfg_we,
  input  logic [lcal_pkg::NODE_W-1:0]   cfg_data,
  output lcal_pkg::out_item_t           out_data
);
  import lcal_pkg::*;

  localparam int AW        = $clog2(MAX_NODES);
  localparam int LW        = $clog2(LIFT_LEVELS);
  localparam int TAW       = LW + AW;
  localparam int TBL_DEPTH = LIFT_LEVELS * (2 ** AW);
  localparam logic [LW-1:0] LVL_TOP = LW'(LIFT_LEVELS - 1);
  localparam logic [NODE_W-1:0] NODE_TOP = NODE_W'(MAX_NODES - 1);

  function automatic logic node_ok(input logic [NODE_W-1:0] n);
    node_ok = (n != '0) && (32'(n) < 32'(MAX_NODES));
  endfunction

  logic [NODE_W-1:0]      node_count_r, node_count_nxt;
  logic [NODE_W-1:0]      x_r, x_nxt;
  logic [NODE_W-1:0]      y_r, y_nxt;
  logic [DEPTH_W-1:0]     depth_r, depth_nxt;
  cmd_t                   cmd_r, cmd_nxt;
  logic [LW-1:0]          lvl_r, lvl_nxt;
  logic [NODE_W-1:0]      j_r, j_nxt;
  logic [NODE_W-1:0]      j1_r, j2_r;
  logic                   v1_r, v2_r;
  logic [LIFT_LEVELS-1:0] diff_r, diff_nxt;
  logic                   pend_r, pend_nxt;
  logic                   tag0_r, tag1_r;
  logic [NODE_W-1:0]      res_r, res_nxt;
  out_item_t              out_r, out_nxt;

  logic [NODE_W-1:0]  last;
  logic [NODE_W-1:0]  rd_node0, rd_node1;
  logic [LW-1:0]      rd_lvl0, rd_lvl1;
  logic [NODE_W-1:0]  tbl_rd0, tbl_rd1, t_eff0, t_eff1;
  logic [DEPTH_W-1:0] lv_rd0, lv_rd1, dx, dy, dbig, dsmall;
  logic [NODE_W-1:0]  x_lift, x_tog, y_tog;
  logic               tog_move, swap;
  logic               tbl_we, lv_we;
  logic [TAW-1:0]     tbl_waddr;
  logic [NODE_W-1:0]  tbl_wdata;

  assign last = (32'(node_count_r) > 32'(MAX_NODES - 1)) ? NODE_TOP : node_count_r;

  assign t_eff0 = tag0_r ? '0 : tbl_rd0;
  assign t_eff1 = tag1_r ? '0 : tbl_rd1;
  assign dx     = tag0_r ? '0 : lv_rd0;
  assign dy     = tag1_r ? '0 : lv_rd1;
  assign swap   = (dx < dy);
  assign dbig   = swap ? dy : dx;
  assign dsmall = swap ? dx : dy;

  assign x_lift   = pend_r ? t_eff0 : x_r;
  assign tog_move = pend_r && (t_eff0 != t_eff1);
  assign x_tog    = tog_move ? t_eff0 : x_r;
  assign y_tog    = tog_move ? t_eff1 : y_r;

  always_comb begin
    rd_node0 = x_r;
    rd_node1 = y_r;
    rd_lvl0  = lvl_r;
    rd_lvl1  = lvl_r;
    case (op)
      OP_QLIFT:  rd_node0 = x_lift;
      OP_QTOG: begin
        rd_node0 = x_tog;
        rd_node1 = y_tog;
      end
      OP_QTEND: begin
        rd_node0 = x_tog;
        rd_lvl0  = '0;
      end
      OP_BISSUE: begin
        rd_node0 = j_r;
        rd_lvl0  = lvl_r - LW'(1);
      end
      default: ;
    endcase
    if (v1_r) begin
      rd_node1 = t_eff0;
      rd_lvl1  = lvl_r - LW'(1);
    end
  end

  assign tbl_we    = ((op == OP_LOAD) && node_ok(x_r)) || v2_r;
  assign tbl_waddr = v2_r ? {lvl_r, AW'(j2_r)} : {LW'(0), AW'(x_r)};
  assign tbl_wdata = v2_r ? t_eff1 : y_r;
  assign lv_we     = (op == OP_LOAD) && node_ok(x_r);

  lcal_ram #(
    .WIDTH (NODE_W),
    .DEPTH (TBL_DEPTH)
  ) u_tbl_ram (
    .clk    (clk),
    .we     (tbl_we),
    .waddr  (tbl_waddr),
    .wdata  (tbl_wdata),
    .raddr0 ({rd_lvl0, AW'(rd_node0)}),
    .rdata0 (tbl_rd0),
    .raddr1 ({rd_lvl1, AW'(rd_node1)}),
    .rdata1 (tbl_rd1)
  );

  lcal_ram #(
    .WIDTH (DEPTH_W),
    .DEPTH (MAX_NODES)
  ) u_lvl_ram (
    .clk    (clk),
    .we     (lv_we),
    .waddr  (AW'(x_r)),
    .wdata  (depth_r),
    .raddr0 (AW'(rd_node0)),
    .rdata0 (lv_rd0),
    .raddr1 (AW'(rd_node1)),
    .rdata1 (lv_rd1)
  );

  always_comb begin
    node_count_nxt = cfg_we ? cfg_data : node_count_r;
    x_nxt          = x_r;
    y_nxt          = y_r;
    depth_nxt      = depth_r;
    cmd_nxt        = cmd_r;
    lvl_nxt        = lvl_r;
    j_nxt          = j_r;
    diff_nxt       = diff_r;
    pend_nxt       = pend_r;
    res_nxt        = res_r;
    out_nxt        = out_r;
    case (op)
      OP_ACCEPT: begin
        x_nxt     = in_data.node_a;
        y_nxt     = in_data.node_b;
        depth_nxt = in_data.node_depth;
        cmd_nxt   = in_data.cmd;
        lvl_nxt   = LW'(1);
        j_nxt     = NODE_W'(1);
        res_nxt   = '0;
      end
      OP_BISSUE: j_nxt = j_r + NODE_W'(1);
      OP_BNEXT: begin
        lvl_nxt = lvl_r + LW'(1);
        j_nxt   = NODE_W'(1);
      end
      OP_QCMP: begin
        if (swap) begin
          x_nxt = y_r;
          y_nxt = x_r;
        end
        diff_nxt = LIFT_LEVELS'(dbig - dsmall);
        lvl_nxt  = LVL_TOP;
        pend_nxt = 1'b0;
      end
      OP_QLIFT: begin
        x_nxt    = x_lift;
        pend_nxt = diff_r[LIFT_LEVELS-1];
        diff_nxt = {diff_r[LIFT_LEVELS-2:0], 1'b0};
        lvl_nxt  = lvl_r - LW'(1);
      end
      OP_QLEND: begin
        x_nxt    = x_lift;
        res_nxt  = x_lift;
        lvl_nxt  = LVL_TOP;
        pend_nxt = 1'b0;
      end
      OP_QTOG: begin
        x_nxt    = x_tog;
        y_nxt    = y_tog;
        pend_nxt = 1'b1;
        lvl_nxt  = lvl_r - LW'(1);
      end
      OP_QFIN: res_nxt = t_eff0;
      OP_OUT: begin
        out_nxt.ancestor  = res_r;
        out_nxt.done_kind = cmd_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NODE_W'(1);
      lvl_r        <= '0;
      j_r          <= '0;
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      pend_r       <= 1'b0;
    end else begin
      node_count_r <= node_count_nxt;
      lvl_r        <= lvl_nxt;
      j_r          <= j_nxt;
      v1_r         <= (op == OP_BISSUE);
      v2_r         <= v1_r;
      pend_r       <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    depth_r <= depth_nxt;
    cmd_r   <= cmd_nxt;
    diff_r  <= diff_nxt;
    res_r   <= res_nxt;
    out_r   <= out_nxt;
    j1_r    <= j_r;
    j2_r    <= j1_r;
    tag0_r  <= !node_ok(rd_node0);
    tag1_r  <= !node_ok(rd_node1);
  end

  assign status.last_zero  = (node_count_r == '0);
  assign status.j_at_last  = (j_r == last);
  assign status.pipe_empty = !v1_r && !v2_r;
  assign status.lvl_top    = (lvl_r == LVL_TOP);
  assign status.lvl_zero   = (lvl_r == '0);
  assign status.x_eq_y     = (x_lift == y_r);

  assign out_data = out_r;

endmodule

### src/lowest_common_ancestor_lifting.sv
// Top level of the ancestor lifting block: controller, datapath and handshakes.
// Depends on lcal_pkg, lcal_ctrl, lcal_dp and lcal_ram.
//
// Answers lowest-common-ancestor queries on a rooted forest by binary lifting. The block
// takes one transaction at a time and returns exactly one result per transaction; a new
// transaction is taken as soon as the previous one has moved into the output register, even
// while that result waits to be collected. A query walks a chain of dependent ancestor table
// reads, one level per cycle: it first aligns the depths and then, unless the nodes already
// coincide, lifts both nodes together. A build sweeps entries 1 to N of each upper level,
// where N is node_count capped at MAX_NODES-1, one entry per cycle through a two-read
// pipeline that is drained between levels. Loads must precede a build, and a build must
// precede queries that rely on upper levels. The configuration port is always ready; write
// it only while the block is idle.
module lowest_common_ancestor_lifting #(
  parameter int MAX_NODES   = lcal_pkg::MAX_NODES_DEF,
  parameter int LIFT_LEVELS = lcal_pkg::LIFT_LEVELS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  lcal_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output lcal_pkg::out_item_t         out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [lcal_pkg::NODE_W-1:0] cfg_data
);
  import lcal_pkg::*;

  dp_op_t     op;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  lcal_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_cmd    (in_data.cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .op        (op),
    .status    (status)
  );

  lcal_dp #(
    .MAX_NODES   (MAX_NODES),
    .LIFT_LEVELS (LIFT_LEVELS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .op       (op),
    .status   (status),
    .in_data  (in_data),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .out_data (out_data)
  );

endmodule

### src/lcal_chk.sv
// Port-level checker for the ancestor lifting block, attached to the top level by bind.
// Depends on lcal_pkg and lowest_common_ancestor_lifting_defines.svh.
`include "lowest_common_ancestor_lifting_defines.svh"

module lcal_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input lcal_pkg::out_item_t out_data
);
  import lcal_pkg::*;

  `LCAL_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "Stalled result changed or vanished.")
  `LCAL_ASSERT_NEXT(a_one_at_a_time, in_valid && !in_stall, in_stall, "A second transaction was taken while one was in progress.")
  `LCAL_ASSERT_SAME(a_nonquery_zero, out_valid && (out_data.done_kind != CMD_QUERY), out_data.ancestor == '0, "A result other than a query carries a non-zero ancestor.")

endmodule

bind lowest_common_ancestor_lifting lcal_chk u_lcal_chk (.*);

### test/lowest_common_ancestor_lifting_tb.sv
// Self-checking testbench for the binary lifting common ancestor block.
// Depends on lcal_pkg and lowest_common_ancestor_lifting; a scoreboard class predicts each answer.
`timescale 1ns / 1ps

module lowest_common_ancestor_lifting_tb;
  import lcal_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 100;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  class ancestor_scoreboard;
    bit [NODE_W-1:0]  anc_tbl [LIFT_LEVELS_DEF][MAX_NODES_DEF];
    bit               tbl_written [LIFT_LEVELS_DEF][MAX_NODES_DEF];
    bit [DEPTH_W-1:0] depth_mem [MAX_NODES_DEF];
    bit               depth_written [MAX_NODES_DEF];
    bit [NODE_W-1:0]  count_reg;
    out_item_t        pending_answers [$];
    bit               touched_unwritten;
    int               errors;

    function new();
      count_reg = 1;
      errors = 0;
    endfunction

    function int unsigned up(int unsigned lvl, int unsigned node);
      if (lvl >= LIFT_LEVELS_DEF || node == 0 || node >= MAX_NODES_DEF) return 0;
      if (!tbl_written[lvl][node]) touched_unwritten = 1;
      return anc_tbl[lvl][node];
    endfunction

    function int unsigned depth_of(int unsigned node);
      if (node == 0 || node >= MAX_NODES_DEF) return 0;
      if (!depth_written[node]) touched_unwritten = 1;
      return depth_mem[node];
    endfunction

    function int unsigned build_last();
      if (count_reg > MAX_NODES_DEF - 1) return MAX_NODES_DEF - 1;
      return count_reg;
    endfunction

    // The sweep only ever reads entries it or a load has written when every node in range
    // has a parent inside the range.
    function bit build_safe();
      int unsigned last;
      last = build_last();
      for (int unsigned j = 1; j <= last; j++) begin
        if (!tbl_written[0][j] || anc_tbl[0][j] > last) return 0;
      end
      return 1;
    endfunction

    function void build_upper_levels();
      int unsigned last;
      last = build_last();
      for (int unsigned lvl = 1; lvl < LIFT_LEVELS_DEF; lvl++) begin
        for (int unsigned j = 1; j <= last; j++) begin
          anc_tbl[lvl][j] = NODE_W'(up(lvl - 1, up(lvl - 1, j)));
          tbl_written[lvl][j] = 1;
        end
      end
    endfunction

    function int unsigned lift_query(int unsigned a, int unsigned b);
      int unsigned x, y, dx, dy, diff, t, px, py;
      x = a;
      y = b;
      dx = depth_of(x);
      dy = depth_of(y);
      if (dx < dy) begin
        t = x; x = y; y = t;
        t = dx; dx = dy; dy = t;
      end
      diff = dx - dy;
      for (int l = LIFT_LEVELS_DEF - 1; l >= 0; l--) begin
        if ((diff >> l) & 1) x = up(l, x);
      end
      if (x == y) return x;
      for (int l = LIFT_LEVELS_DEF - 1; l >= 0; l--) begin
        px = up(l, x);
        py = up(l, y);
        if (px != py) begin
          x = px;
          y = py;
        end
      end
      return up(0, x);
    endfunction

    function bit query_safe(int unsigned a, int unsigned b);
      int unsigned dummy;
      touched_unwritten = 0;
      dummy = lift_query(a, b);
      return !touched_unwritten;
    endfunction

    function out_item_t apply_item(in_item_t it);
      out_item_t res;
      res.ancestor = '0;
      res.done_kind = it.cmd;
      case (it.cmd)
        CMD_LOAD: begin
          if (it.node_a != 0) begin
            anc_tbl[0][it.node_a] = it.node_b;
            tbl_written[0][it.node_a] = 1;
            depth_mem[it.node_a] = it.node_depth;
            depth_written[it.node_a] = 1;
          end
        end
        CMD_BUILD: build_upper_levels();
        CMD_QUERY: res.ancestor = NODE_W'(lift_query(it.node_a, it.node_b));
        default: ;
      endcase
      return res;
    endfunction

    function void note_item(in_item_t it);
      pending_answers = {pending_answers, apply_item(it)};
    endfunction

    function void check_answer(out_item_t got);
      out_item_t want;
      if (pending_answers.size() == 0) begin
        $error("unexpected result: ancestor %0d, done_kind %0d", got.ancestor, got.done_kind);
        errors++;
        return;
      end
      want = pending_answers.pop_front();
      if (got.ancestor !== want.ancestor) begin
        $error("ancestor mismatch: expected %0d, actual %0d", want.ancestor, got.ancestor);
        errors++;
      end
      if (got.done_kind !== want.done_kind) begin
        $error("done_kind mismatch: expected %0d, actual %0d", want.done_kind, got.done_kind);
        errors++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  in_item_t            in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [NODE_W-1:0]   cfg_data = '0;

  ancestor_scoreboard  sb = new();
  int                  send_pct = 0;
  int                  recv_pct = 0;
  bit                  hold_req = 0;
  bit                  hold_done = 0;
  int                  hold_left = 0;
  int                  cycle_count = 0;

  lowest_common_ancestor_lifting u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Result side: checks each collected result and chooses the next stall.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_answer(out_data);
    if (hold_req && !hold_done) begin
      hold_done = 1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_pct);
    end
  end

  function automatic in_item_t make_item(cmd_t c, int unsigned a, int unsigned b,
                                         int unsigned d);
    in_item_t it;
    it.cmd = c;
    it.node_a = NODE_W'(a);
    it.node_b = NODE_W'(b);
    it.node_depth = DEPTH_W'(d);
    return it;
  endfunction

  task automatic set_idle(input idle_mode_t mode);
    case (mode)
      IDLE_NONE:     begin send_pct = 0;  recv_pct = 0;  end
      IDLE_SENDER:   begin send_pct = 87; recv_pct = 0;  end
      IDLE_RECEIVER: begin send_pct = 0;  recv_pct = 87; end
      default:       begin send_pct = 13; recv_pct = 13; end
    endcase
  endtask

  task automatic send_item(input in_item_t it);
    if ($urandom_range(0, 99) < send_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_pct);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    sb.note_item(it);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_answers.size() != 0) @(posedge clk);
  endtask

  task automatic set_node_count(input int unsigned value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= NODE_W'(value);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.count_reg = NODE_W'(value);
  endtask

  task automatic send_query(input int unsigned qlim, input bit with_zero);
    int unsigned a, b;
    a = 0;
    b = 0;
    for (int tries = 0; tries < 16; tries++) begin
      if ($urandom_range(0, 9) == 0) a = $urandom_range(0, 1023);
      else a = $urandom_range(0, qlim);
      b = $urandom_range(0, qlim);
      if (with_zero) a = 0;
      if ($urandom_range(0, 1)) begin
        a = a ^ b; b = a ^ b; a = a ^ b;
      end
      if (sb.query_safe(a, b)) break;
      a = 0;
      b = 0;
    end
    send_item(make_item(CMD_QUERY, a, b, $urandom_range(0, 2047)));
  endtask

  // Random forest over nodes 1..n: parents always precede their children, roots mostly at
  // depth one, and the loads go out in shuffled order.
  task automatic load_forest(input int unsigned n, input int unsigned chain_pct);
    int unsigned par [MAX_NODES_DEF];
    int unsigned dep [MAX_NODES_DEF];
    int unsigned order [$];
    int unsigned s, t;
    for (int unsigned j = 1; j <= n; j++) begin
      if (j > 1 && $urandom_range(0, 99) < chain_pct) par[j] = j - 1;
      else if (j == 1 || $urandom_range(0, 99) < 15) par[j] = 0;
      else par[j] = $urandom_range(1, j - 1);
      if (par[j] == 0) dep[j] = ($urandom_range(0, 99) < 20) ? $urandom_range(1, 1024) : 1;
      else dep[j] = dep[par[j]] + 1;
      order = {order, j};
    end
    for (int k = order.size() - 1; k > 0; k--) begin
      s = $urandom_range(0, k);
      t = order[k];
      order[k] = order[s];
      order[s] = t;
    end
    foreach (order[k]) send_item(make_item(CMD_LOAD, order[k], par[order[k]], dep[order[k]]));
  endtask

  task automatic run_phase(input int unsigned n, input int unsigned n_rand,
                           input int unsigned chain_pct, input idle_mode_t mode,
                           input bit with_hold);
    int unsigned qlim, span, r, a, b;
    set_node_count(n);
    set_idle(mode);
    qlim = (n > 0) ? n : 40;
    span = (n > 0) ? n : 1;
    if (n > 0) load_forest(n, chain_pct);
    if (sb.build_safe()) send_item(make_item(CMD_BUILD, 0, 0, 0));
    for (int unsigned i = 0; i < n_rand; i++) begin
      if (with_hold && i == n_rand / 2) hold_req = 1;
      r = $urandom_range(0, 99);
      if (r < 70) begin
        send_query(qlim, 1'b0);
      end else if (r < 80) begin
        if ($urandom_range(0, 3) == 0) begin
          a = $urandom_range(0, 1023);
          b = $urandom_range(0, 1023);
        end else begin
          a = $urandom_range(1, span);
          b = $urandom_range(0, n);
        end
        send_item(make_item(CMD_LOAD, a, b, $urandom_range(1, 2047)));
      end else if (r < 88) begin
        if (sb.build_safe()) send_item(make_item(CMD_BUILD, $urandom_range(0, 1023),
                                                 $urandom_range(0, 1023),
                                                 $urandom_range(0, 2047)));
        else send_query(qlim, 1'b0);
      end else if (r < 93) begin
        send_item(make_item(CMD_NONE, $urandom_range(0, 1023), $urandom_range(0, 1023),
                            $urandom_range(0, 2047)));
      end else begin
        send_query(qlim, 1'b1);
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    set_idle(IDLE_BOTH);

    // Reset value of node_count covers node 1 only.
    send_item(make_item(CMD_NONE, 1023, 1023, 2047));
    send_item(make_item(CMD_QUERY, 0, 0, 0));
    send_item(make_item(CMD_LOAD, 0, 1023, 2047));
    send_item(make_item(CMD_LOAD, 1, 0, 1));
    send_item(make_item(CMD_BUILD, 0, 0, 0));
    send_item(make_item(CMD_QUERY, 1, 1, 0));
    send_item(make_item(CMD_QUERY, 1, 0, 0));
    send_item(make_item(CMD_QUERY, 0, 1, 0));

    // Two trees and a deep-rooted one, plus a stored node outside the swept range.
    set_node_count(10);
    send_item(make_item(CMD_LOAD, 2, 1, 2));
    send_item(make_item(CMD_LOAD, 3, 1, 2));
    send_item(make_item(CMD_LOAD, 4, 2, 3));
    send_item(make_item(CMD_LOAD, 5, 4, 4));
    send_item(make_item(CMD_LOAD, 6, 5, 5));
    send_item(make_item(CMD_LOAD, 7, 0, 1));
    send_item(make_item(CMD_LOAD, 8, 7, 2));
    send_item(make_item(CMD_LOAD, 9, 0, 1024));
    send_item(make_item(CMD_LOAD, 10, 9, 1025));
    send_item(make_item(CMD_LOAD, 1023, 1023, 2047));
    send_item(make_item(CMD_BUILD, 0, 0, 0));
    send_item(make_item(CMD_QUERY, 6, 3, 0));
    send_item(make_item(CMD_QUERY, 5, 6, 0));
    send_item(make_item(CMD_QUERY, 8, 6, 0));
    send_item(make_item(CMD_QUERY, 10, 9, 0));
    send_item(make_item(CMD_QUERY, 10, 1, 0));

    run_phase(12, 120, 20, IDLE_NONE, 1'b1);
    run_phase(30, 120, 30, IDLE_SENDER, 1'b0);
    run_phase(0, 30, 0, IDLE_RECEIVER, 1'b0);
    run_phase(1023, 60, 90, IDLE_NONE, 1'b0);
    run_phase(7, 60, 40, IDLE_BOTH, 1'b0);
    run_phase(20, 40, 10, IDLE_RECEIVER, 1'b0);
    run_phase(1, 20, 0, IDLE_SENDER, 1'b0);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending_answers.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
